// ===== src/assert_macros.svh =====
// Assertion helpers. Every check is sampled on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== src/asr_pkg.sv =====
package asr_pkg;

  localparam int SYM_BITS = 8;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  // Operation codes of a request.
  localparam logic [2:0] FUNC_LOAD_REF  = 3'd0;
  localparam logic [2:0] FUNC_LOAD_COST = 3'd1;
  localparam logic [2:0] FUNC_INIT_ROW  = 3'd2;
  localparam logic [2:0] FUNC_PROCESS   = 3'd3;
  localparam logic [2:0] FUNC_READ_ROW  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_COST   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REF_LENGTH = 1'd1;

  typedef struct packed {
    logic [2:0]          func;
    logic [10:0]         position;
    logic [SYM_BITS-1:0] sym_a;
    logic [SYM_BITS-1:0] sym_b;
    logic [15:0]         cost_value;
  } in_req_t;

  typedef struct packed {
    logic [31:0] score;
    logic        saturated;
  } out_res_t;

endpackage

// ===== src/alignment_score_row_unit.sv =====
// Loads and unused codes answer in the cycle after the request; a row read passes through the
// row memory read register, then the output register. An init and a query symbol go one row
// cell per cycle through the row memory over the L cells, L being the row length.
// Throughput: loads are taken every cycle while idle; the others hold busy until they finish.
// Results cannot be stalled. Reset clears control state and the saturation flag and sets
// gap_cost to 1 and ref_length to 0; the memories are not cleared.
`include "assert_macros.svh"

module alignment_score_row_unit #(
  parameter int MAX_REF    = 1024,
  parameter int COST_BITS  = 16,
  parameter int SCORE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  asr_pkg::in_req_t                    in_req,
  output logic                                out_valid,
  output asr_pkg::out_res_t                   out_res,
  input  logic                                cfg_we,
  input  logic [asr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [asr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int RW = $clog2(MAX_REF + 1);
  localparam int KW = $clog2(MAX_REF);
  localparam int PW = (RW > 11) ? RW : 11;
  localparam int SW = ((SCORE_BITS > COST_BITS) ? SCORE_BITS : COST_BITS) + 1;
  localparam int CW = 2 * asr_pkg::SYM_BITS;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INIT  = 5'b00010,
    S_PZERO = 5'b00100,
    S_PRUN  = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  function automatic logic [SCORE_BITS-1:0] sat_add(input logic [SCORE_BITS-1:0] a,
                                                    input logic [SW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + b;
    if (s >= SW'(SCORE_MAX)) return SCORE_MAX;
    return s[SCORE_BITS-1:0];
  endfunction

  // Memories
  logic [asr_pkg::SYM_BITS-1:0] ref_mem  [MAX_REF];
  logic [COST_BITS-1:0]         cost_mem [2**CW];
  logic [SCORE_BITS-1:0]        row_mem  [MAX_REF+1];

  logic                         ref_we, ref_re;
  logic [KW-1:0]                ref_waddr, ref_raddr;
  logic [asr_pkg::SYM_BITS-1:0] ref_wdata, ref_rdata;
  logic                         cost_we, cost_re;
  logic [CW-1:0]                cost_waddr, cost_raddr;
  logic [COST_BITS-1:0]         cost_wdata, cost_rdata;
  logic                         row_we, row_re;
  logic [RW-1:0]                row_waddr, row_raddr;
  logic [SCORE_BITS-1:0]        row_wdata, row_rdata;

  always_ff @(posedge clk) begin
    if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
    if (ref_re) ref_rdata <= ref_mem[ref_raddr];
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
    if (cost_re) cost_rdata <= cost_mem[cost_raddr];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (row_re) row_rdata <= row_mem[row_raddr];
  end

  // Registers
  state_t                       state_r, state_nxt;
  logic [15:0]                  gap_r;
  logic [10:0]                  len_r;
  logic                         flag_r, flag_nxt;
  logic [SCORE_BITS-1:0]        left_r, left_nxt;
  logic [SCORE_BITS-1:0]        diag_r, diag_nxt;
  logic [asr_pkg::SYM_BITS-1:0] sym_r, sym_nxt;
  logic [RW-1:0]                iss_r, iss_nxt;
  logic                         p1_v_r, p1_v_nxt;
  logic [RW-1:0]                j1_r, j1_nxt;
  logic                         p2_v_r, p2_v_nxt;
  logic [RW-1:0]                j2_r, j2_nxt;
  logic                         rd_ok_r, rd_ok_nxt;
  logic                         out_v_r, out_v_nxt;
  asr_pkg::out_res_t            out_r, out_nxt;

  logic                  accept;
  logic [RW-1:0]         len_eff;
  logic [PW-1:0]         pos_ext;
  logic [SW-1:0]         gap_ext;
  logic [SCORE_BITS-1:0] acc_s, new0_s, up_s, left_s, dg_s, m_s;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign pos_ext = PW'(in_req.position);
  assign gap_ext = SW'(gap_r);
  assign len_eff = (32'(len_r) > 32'(MAX_REF)) ? RW'(MAX_REF) : RW'(len_r);

  // Cell arithmetic: init accumulator, entry zero and the three candidates of one cell.
  always_comb begin
    acc_s  = sat_add(left_r, gap_ext);
    new0_s = sat_add(row_rdata, gap_ext);
    left_s = sat_add(left_r, gap_ext);
    up_s   = sat_add(row_rdata, gap_ext);
    dg_s   = sat_add(diag_r, SW'(cost_rdata));
    m_s    = (left_s < up_s) ? left_s : up_s;
    if (dg_s < m_s) m_s = dg_s;
  end

  always_comb begin
    state_nxt  = state_r;
    flag_nxt   = flag_r;
    left_nxt   = left_r;
    diag_nxt   = diag_r;
    sym_nxt    = sym_r;
    iss_nxt    = iss_r;
    p1_v_nxt   = 1'b0;
    j1_nxt     = j1_r;
    p2_v_nxt   = 1'b0;
    j2_nxt     = j2_r;
    rd_ok_nxt  = rd_ok_r;
    out_v_nxt  = 1'b0;
    out_nxt    = out_r;
    ref_we     = 1'b0;
    ref_waddr  = pos_ext[KW-1:0];
    ref_wdata  = in_req.sym_a;
    ref_re     = 1'b0;
    ref_raddr  = iss_r[KW-1:0];
    cost_we    = 1'b0;
    cost_waddr = {in_req.sym_a, in_req.sym_b};
    cost_wdata = COST_BITS'(in_req.cost_value);
    cost_re    = 1'b0;
    cost_raddr = {sym_r, ref_rdata};
    row_we     = 1'b0;
    row_waddr  = j2_r;
    row_wdata  = m_s;
    row_re     = 1'b0;
    row_raddr  = j1_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.score     = '0;
          out_nxt.saturated = flag_r;
          unique case (in_req.func)
            asr_pkg::FUNC_LOAD_REF: begin
              ref_we    = (32'(in_req.position) < 32'(MAX_REF));
              out_v_nxt = 1'b1;
            end
            asr_pkg::FUNC_LOAD_COST: begin
              cost_we   = 1'b1;
              out_v_nxt = 1'b1;
            end
            asr_pkg::FUNC_INIT_ROW: begin
              flag_nxt  = 1'b0;
              row_we    = 1'b1;
              row_waddr = '0;
              row_wdata = '0;
              left_nxt  = '0;
              iss_nxt   = RW'(1);
              if (len_eff == '0) begin
                out_v_nxt         = 1'b1;
                out_nxt.saturated = 1'b0;
              end else begin
                state_nxt = S_INIT;
              end
            end
            asr_pkg::FUNC_PROCESS: begin
              row_re    = 1'b1;
              row_raddr = '0;
              sym_nxt   = in_req.sym_a;
              iss_nxt   = '0;
              state_nxt = S_PZERO;
            end
            asr_pkg::FUNC_READ_ROW: begin
              rd_ok_nxt = (32'(in_req.position) <= 32'(MAX_REF));
              row_re    = 1'b1;
              row_raddr = pos_ext[RW-1:0];
              state_nxt = S_READ;
            end
            default: begin
              out_v_nxt = 1'b1;
            end
          endcase
        end
      end

      S_INIT: begin
        row_we    = 1'b1;
        row_waddr = iss_r;
        row_wdata = acc_s;
        left_nxt  = acc_s;
        flag_nxt  = flag_r | (acc_s == SCORE_MAX);
        iss_nxt   = iss_r + RW'(1);
        if (iss_r == len_eff) begin
          out_v_nxt         = 1'b1;
          out_nxt.score     = 32'(acc_s);
          out_nxt.saturated = flag_r | (acc_s == SCORE_MAX);
          state_nxt         = S_IDLE;
        end
      end

      S_READ: begin
        out_v_nxt         = 1'b1;
        out_nxt.score     = rd_ok_r ? 32'(row_rdata) : '0;
        out_nxt.saturated = flag_r;
        state_nxt         = S_IDLE;
      end

      S_PZERO: begin
        // Entry zero only gains a gap; the old value becomes the first diagonal.
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = new0_s;
        left_nxt  = new0_s;
        diag_nxt  = row_rdata;
        flag_nxt  = flag_r | (new0_s == SCORE_MAX);
        if (len_eff == '0) begin
          out_v_nxt         = 1'b1;
          out_nxt.score     = 32'(new0_s);
          out_nxt.saturated = flag_r | (new0_s == SCORE_MAX);
          state_nxt         = S_IDLE;
        end else begin
          ref_re    = 1'b1;
          p1_v_nxt  = 1'b1;
          j1_nxt    = RW'(1);
          iss_nxt   = RW'(1);
          state_nxt = S_PRUN;
        end
      end

      S_PRUN: begin
        // Three steps in flight: reference symbol read, cost and up reads, cell update.
        if (iss_r < len_eff) begin
          ref_re   = 1'b1;
          p1_v_nxt = 1'b1;
          j1_nxt   = iss_r + RW'(1);
          iss_nxt  = iss_r + RW'(1);
        end
        if (p1_v_r) begin
          cost_re = 1'b1;
          row_re  = 1'b1;
        end
        p2_v_nxt = p1_v_r;
        j2_nxt   = j1_r;
        if (p2_v_r) begin
          row_we   = 1'b1;
          left_nxt = m_s;
          diag_nxt = row_rdata;
          flag_nxt = flag_r | (left_s == SCORE_MAX) | (up_s == SCORE_MAX) |
                     (dg_s == SCORE_MAX);
          if (j2_r == len_eff) begin
            out_v_nxt         = 1'b1;
            out_nxt.score     = 32'(m_s);
            out_nxt.saturated = flag_nxt;
            p1_v_nxt          = 1'b0;
            p2_v_nxt          = 1'b0;
            state_nxt         = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flag_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      gap_r   <= 16'd1;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      flag_r  <= flag_nxt;
      p1_v_r  <= p1_v_nxt;
      p2_v_r  <= p2_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        if (cfg_index == asr_pkg::CFG_GAP_COST) gap_r <= cfg_wdata;
        if (cfg_index == asr_pkg::CFG_REF_LENGTH) len_r <= cfg_wdata[10:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    diag_r  <= diag_nxt;
    sym_r   <= sym_nxt;
    iss_r   <= iss_nxt;
    j1_r    <= j1_nxt;
    j2_r    <= j2_nxt;
    rd_ok_r <= rd_ok_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

  `ASSERT_IMPLIES(a_p2_in_run, p2_v_r, state_r == S_PRUN, "cell update outside a row pass")
  `ASSERT_IMPLIES(a_stage_order, p1_v_r && p2_v_r, j1_r == j2_r + RW'(1),
                  "row pipeline cells out of order")
  `ASSERT_NEVER(a_run_not_empty, state_r == S_PRUN && !p1_v_r && !p2_v_r,
                "row pass has drained without finishing")
  `ASSERT_NEXT(a_proc_busy, accept && in_req.func == asr_pkg::FUNC_PROCESS,
               busy && !out_valid, "query request did not start a row pass")

endmodule
